/* design/ttdhc_pkg.sv */
// ----------------------------------------------------------------------------
// ttdhc_pkg
// Types and constants shared by the turn-then-drive heading controller.
// ----------------------------------------------------------------------------
package ttdhc_pkg;

   localparam int ANG_W   = 19;
   localparam int CORD_W  = 56;
   localparam int SRC_W   = 34;
   localparam int STEP_W  = 4;
   localparam int STEPS   = 16;

   localparam logic signed [ANG_W-1:0] ANG_HALF_PI = 19'sd102944;
   localparam logic [19:0]             ANG_PI      = 20'd205887;

   localparam logic [1:0] MODE_TICK = 2'd0;
   localparam logic [1:0] MODE_GOAL = 2'd1;
   localparam logic [1:0] MODE_STOP = 2'd2;

   localparam logic [2:0] CSR_RATE_GAIN  = 3'd0;
   localparam logic [2:0] CSR_ARRIVE     = 3'd1;
   localparam logic [2:0] CSR_ALIGN      = 3'd2;
   localparam logic [2:0] CSR_CRUISE     = 3'd3;
   localparam logic [2:0] CSR_MAX_TURN   = 3'd4;

   localparam logic [3:0] MUL_CWZ  = 4'd0;
   localparam logic [3:0] MUL_CWW  = 4'd1;
   localparam logic [3:0] MUL_CZZ  = 4'd2;
   localparam logic [3:0] MUL_DXX  = 4'd3;
   localparam logic [3:0] MUL_DYY  = 4'd4;
   localparam logic [3:0] MUL_ARR  = 4'd5;
   localparam logic [3:0] MUL_TWZ  = 4'd6;
   localparam logic [3:0] MUL_TWW  = 4'd7;
   localparam logic [3:0] MUL_TZZ  = 4'd8;
   localparam logic [3:0] MUL_GAIN = 4'd9;

   typedef struct packed {
      logic [1:0]         mode;
      logic signed [31:0] current_x;
      logic signed [31:0] current_y;
      logic signed [15:0] current_qz;
      logic signed [15:0] current_qw;
      logic signed [31:0] target_x;
      logic signed [31:0] target_y;
      logic signed [15:0] target_qz;
      logic signed [15:0] target_qw;
   } req_type;

   typedef struct packed {
      logic [14:0]        linear_velocity;
      logic signed [15:0] angular_velocity;
      logic               done_res;
      logic               arrived;
   } rsp_type;

   typedef struct packed {
      logic              capture;
      logic              mul_en;
      logic [3:0]        mul_sel;
      logic              cinit;
      logic              second;
      logic              citer;
      logic [STEP_W-1:0] iter;
      logic              diff_en;
      logic              mod_en;
      logic              out_load;
      logic              out_stop;
   } cmd_type;

   typedef struct packed {
      logic mod_busy;
      logic arrive_done;
   } sts_type;

   function automatic logic signed [ANG_W-1:0] atan_entry(input logic [STEP_W-1:0] i);
      logic signed [ANG_W-1:0] r;
      case (i)
         4'd0:    r = 19'sd51472;
         4'd1:    r = 19'sd30386;
         4'd2:    r = 19'sd16055;
         4'd3:    r = 19'sd8150;
         4'd4:    r = 19'sd4091;
         4'd5:    r = 19'sd2047;
         4'd6:    r = 19'sd1024;
         4'd7:    r = 19'sd512;
         4'd8:    r = 19'sd256;
         4'd9:    r = 19'sd128;
         4'd10:   r = 19'sd64;
         4'd11:   r = 19'sd32;
         4'd12:   r = 19'sd16;
         4'd13:   r = 19'sd8;
         4'd14:   r = 19'sd4;
         default: r = 19'sd2;
      endcase
      return r;
   endfunction

endpackage

/* design/ttdhc_ctrl.sv */
// ----------------------------------------------------------------------------
// ttdhc_ctrl
// Sequencer: multiply steps, two CORDIC passes, angle wrap, gain, result beat.
// ----------------------------------------------------------------------------
module ttdhc_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_mode,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ttdhc_pkg::cmd_type cmd,
   input  ttdhc_pkg::sts_type sts
);
   import ttdhc_pkg::*;

   typedef enum logic [7:0] {
      ST_IDLE   = 8'b0000_0001,
      ST_MUL    = 8'b0000_0010,
      ST_CINIT  = 8'b0000_0100,
      ST_CITER  = 8'b0000_1000,
      ST_DIFF   = 8'b0001_0000,
      ST_MOD    = 8'b0010_0000,
      ST_GAIN   = 8'b0100_0000,
      ST_FINISH = 8'b1000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              pass_ff, pass_in;
   logic              active_ff, active_in;
   logic              stop_ff, stop_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              accept;

   assign req_ready = (state_ff == ST_IDLE);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      pass_in   = pass_ff;
      active_in = active_ff;
      stop_in   = stop_ff;
      cmd       = '0;
      cmd.capture = accept;
      cmd.iter    = cnt_ff;
      cmd.second  = pass_ff;
      cmd.mul_sel = (state_ff == ST_GAIN) ? MUL_GAIN : cnt_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_mode)
                  MODE_TICK: begin
                     if (active_ff) begin
                        cnt_in   = '0;
                        state_in = ST_MUL;
                     end
                  end
                  MODE_GOAL: active_in = 1'b1;
                  MODE_STOP: begin
                     stop_in  = 1'b1;
                     state_in = ST_FINISH;
                  end
                  default: ;
               endcase
            end
         end
         ST_MUL: begin
            cmd.mul_en = 1'b1;
            if (cnt_ff == MUL_TZZ) begin
               pass_in  = 1'b0;
               state_in = ST_CINIT;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_CINIT: begin
            cmd.cinit = 1'b1;
            cnt_in    = '0;
            state_in  = ST_CITER;
         end
         ST_CITER: begin
            cmd.citer = 1'b1;
            cnt_in    = cnt_ff + 1'b1;
            if (cnt_ff == STEP_W'(STEPS - 1)) begin
               if (!pass_ff) begin
                  pass_in  = 1'b1;
                  state_in = ST_CINIT;
               end else begin
                  state_in = ST_DIFF;
               end
            end
         end
         ST_DIFF: begin
            cmd.diff_en = 1'b1;
            state_in    = ST_MOD;
         end
         ST_MOD: begin
            cmd.mod_en = 1'b1;
            if (!sts.mod_busy) state_in = ST_GAIN;
         end
         ST_GAIN: begin
            cmd.mul_en = 1'b1;
            stop_in    = 1'b0;
            state_in   = ST_FINISH;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               cmd.out_stop = stop_ff;
               if (stop_ff || sts.arrive_done) active_in = 1'b0;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
      rsp_valid_in = cmd.out_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         pass_ff      <= 1'b0;
         active_ff    <= 1'b0;
         stop_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         pass_ff      <= pass_in;
         active_ff    <= active_in;
         stop_ff      <= stop_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* design/ttdhc_datapath.sv */
// ----------------------------------------------------------------------------
// ttdhc_datapath
// Shared multiplier, CORDIC vectoring unit, angle wrap, gain and clamp.
// ----------------------------------------------------------------------------
module ttdhc_datapath (
   input  logic               clock,
   input  logic               reset,
   input  ttdhc_pkg::req_type req_payload,
   output ttdhc_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wdata,
   input  ttdhc_pkg::cmd_type cmd,
   output ttdhc_pkg::sts_type sts
);
   import ttdhc_pkg::*;

   logic [15:0] rate_gain_ff;
   logic [30:0] arrive_ff;
   logic [14:0] align_ff, cruise_ff, max_turn_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rate_gain_ff <= 16'd256;
         arrive_ff    <= 31'd6554;
         align_ff     <= 15'd4096;
         cruise_ff    <= 15'd819;
         max_turn_ff  <= 15'd8192;
      end else if (csr_we) begin
         case (csr_index)
            CSR_RATE_GAIN: rate_gain_ff <= csr_wdata[15:0];
            CSR_ARRIVE:    arrive_ff    <= csr_wdata;
            CSR_ALIGN:     align_ff     <= csr_wdata[14:0];
            CSR_CRUISE:    cruise_ff    <= csr_wdata[14:0];
            CSR_MAX_TURN:  max_turn_ff  <= csr_wdata[14:0];
            default: ;
         endcase
      end
   end

   req_type in_ff;
   always_ff @(posedge clock) begin
      if (cmd.capture) in_ff <= req_payload;
   end

   logic signed [32:0] dx, dy;
   logic [32:0]        adx, ady;
   logic               big;
   assign dx  = 33'(in_ff.target_x) - 33'(in_ff.current_x);
   assign dy  = 33'(in_ff.target_y) - 33'(in_ff.current_y);
   assign adx = dx[32] ? 33'(-dx) : 33'(dx);
   assign ady = dy[32] ? 33'(-dy) : 33'(dy);
   assign big = adx[32] | adx[31] | ady[32] | ady[31];

   // shared multiplier
   logic signed [32:0] ma, mb;
   logic signed [65:0] prod;
   logic signed [19:0] e;
   always_comb begin
      ma = '0;
      mb = '0;
      case (cmd.mul_sel)
         MUL_CWZ:  begin ma = 33'(in_ff.current_qw); mb = 33'(in_ff.current_qz); end
         MUL_CWW:  begin ma = 33'(in_ff.current_qw); mb = 33'(in_ff.current_qw); end
         MUL_CZZ:  begin ma = 33'(in_ff.current_qz); mb = 33'(in_ff.current_qz); end
         MUL_DXX:  begin ma = {1'b0, adx[31:0]}; mb = {1'b0, adx[31:0]}; end
         MUL_DYY:  begin ma = {1'b0, ady[31:0]}; mb = {1'b0, ady[31:0]}; end
         MUL_ARR:  begin ma = {2'b0, arrive_ff}; mb = {2'b0, arrive_ff}; end
         MUL_TWZ:  begin ma = 33'(in_ff.target_qw); mb = 33'(in_ff.target_qz); end
         MUL_TWW:  begin ma = 33'(in_ff.target_qw); mb = 33'(in_ff.target_qw); end
         MUL_TZZ:  begin ma = 33'(in_ff.target_qz); mb = 33'(in_ff.target_qz); end
         MUL_GAIN: begin ma = 33'(e); mb = {17'b0, rate_gain_ff}; end
         default: ;
      endcase
   end
   assign prod = 66'(ma) * 66'(mb);

   logic signed [31:0] cwz_ff, cww_ff, czz_ff, twz_ff, tww_ff, tzz_ff;
   logic [63:0]        dx2_ff, dy2_ff, ar2_ff;
   logic signed [35:0] p_ff;
   always_ff @(posedge clock) begin
      if (cmd.mul_en) begin
         case (cmd.mul_sel)
            MUL_CWZ:  cwz_ff <= prod[31:0];
            MUL_CWW:  cww_ff <= prod[31:0];
            MUL_CZZ:  czz_ff <= prod[31:0];
            MUL_DXX:  dx2_ff <= prod[63:0];
            MUL_DYY:  dy2_ff <= prod[63:0];
            MUL_ARR:  ar2_ff <= prod[63:0];
            MUL_TWZ:  twz_ff <= prod[31:0];
            MUL_TWW:  tww_ff <= prod[31:0];
            MUL_TZZ:  tzz_ff <= prod[31:0];
            MUL_GAIN: p_ff   <= prod[35:0];
            default: ;
         endcase
      end
   end

   // CORDIC vectoring
   logic signed [CORD_W-1:0] x_ff, y_ff, xs, ys, sx_sh, sy_sh;
   logic signed [ANG_W-1:0]  z_ff, heading, yaw_ff;
   logic                     zero_ff, within_ff;
   logic signed [SRC_W-1:0]  src_x, src_y;

   always_comb begin
      if (!cmd.second) begin
         src_x = SRC_W'(cww_ff) - SRC_W'(czz_ff);
         src_y = SRC_W'(cwz_ff) <<< 1;
      end else if (within_ff) begin
         src_x = SRC_W'(tww_ff) - SRC_W'(tzz_ff);
         src_y = SRC_W'(twz_ff) <<< 1;
      end else begin
         src_x = SRC_W'(dx);
         src_y = SRC_W'(dy);
      end
   end

   assign xs      = CORD_W'(src_x) <<< 20;
   assign ys      = CORD_W'(src_y) <<< 20;
   assign sx_sh   = x_ff >>> cmd.iter;
   assign sy_sh   = y_ff >>> cmd.iter;
   assign heading = zero_ff ? '0 : z_ff;

   always_ff @(posedge clock) begin
      if (cmd.cinit) begin
         zero_ff <= (src_x == '0) && (src_y == '0);
         if (xs < 0) begin
            if (ys >= 0) begin
               x_ff <= ys;
               y_ff <= -xs;
               z_ff <= ANG_HALF_PI;
            end else begin
               x_ff <= -ys;
               y_ff <= xs;
               z_ff <= -ANG_HALF_PI;
            end
         end else begin
            x_ff <= xs;
            y_ff <= ys;
            z_ff <= '0;
         end
         if (cmd.second) yaw_ff <= heading;
         else within_ff <= !big && ((dx2_ff + dy2_ff) < ar2_ff);
      end else if (cmd.citer) begin
         if (y_ff >= 0) begin
            x_ff <= x_ff + sy_sh;
            y_ff <= y_ff - sx_sh;
            z_ff <= z_ff + atan_entry(cmd.iter);
         end else begin
            x_ff <= x_ff - sy_sh;
            y_ff <= y_ff + sx_sh;
            z_ff <= z_ff - atan_entry(cmd.iter);
         end
      end
   end

   // truncating remainder by pi
   logic signed [19:0] diff;
   logic [19:0]        m_ff;
   logic               neg_ff;
   assign diff         = 20'(heading) - 20'(yaw_ff);
   assign sts.mod_busy = (m_ff >= ANG_PI);
   assign e            = neg_ff ? -20'(signed'(m_ff)) : 20'(signed'(m_ff));

   always_ff @(posedge clock) begin
      if (cmd.diff_en) begin
         neg_ff <= diff[19];
         m_ff   <= diff[19] ? 20'(-diff) : 20'(diff);
      end else if (cmd.mod_en && sts.mod_busy) begin
         m_ff <= m_ff - ANG_PI;
      end
   end

   // rate, alignment, clamp
   logic signed [35:0] p_adj;
   logic signed [23:0] w, wc, lim;
   logic [23:0]        aw;
   logic               aligned;
   logic [14:0]        v;
   assign p_adj   = p_ff + (p_ff[35] ? 36'sd4095 : 36'sd0);
   assign w       = p_adj[35:12];
   assign aw      = w[23] ? 24'(-w) : 24'(w);
   assign aligned = aw < {9'b0, align_ff};
   assign lim     = {9'b0, max_turn_ff};
   assign wc      = (w < -lim) ? -lim : ((w > lim) ? lim : w);
   assign v       = (!within_ff && aligned) ? cruise_ff : '0;
   assign sts.arrive_done = within_ff && aligned;

   rsp_type out_ff;
   assign rsp_payload = out_ff;
   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         if (cmd.out_stop) begin
            out_ff <= '0;
         end else if (sts.arrive_done) begin
            out_ff <= {15'd0, 16'd0, 1'b0, 1'b1};
         end else begin
            out_ff.linear_velocity  <= v;
            out_ff.angular_velocity <= wc[15:0];
            out_ff.done_res         <= (v == '0) && (wc == '0);
            out_ff.arrived          <= 1'b0;
         end
      end
   end

endmodule

/* design/turn_then_drive_heading_controller_core.sv */
// ----------------------------------------------------------------------------
// turn_then_drive_heading_controller_core
// Turn-then-drive steering step for a planar robot.
// ----------------------------------------------------------------------------
// One item at a time. A tick while armed runs nine steps on the one shared
// multiplier, two CORDIC passes (heading of the pose, then either the heading of
// the target or the bearing to the target point), up to two wrap subtractions,
// the gain multiply and the result load. A finished result waits in the output
// register while the next beat is taken.
module turn_then_drive_heading_controller_core (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  ttdhc_pkg::req_type req_payload,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ttdhc_pkg::rsp_type rsp_payload,
   input  logic               csr_we,
   input  logic [2:0]         csr_index,
   input  logic [30:0]        csr_wdata
);
   import ttdhc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   ttdhc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_mode  (req_payload.mode),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .sts       (sts)
   );

   ttdhc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload),
      .csr_we      (csr_we),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule

/* tb/sv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the turn-then-drive heading controller core.
// Random and directed goal, stop and tick beats are checked against an
// in-bench model of the CORDIC heading, wrap and turn-rate arithmetic.
// ----------------------------------------------------------------------------
module tb;
   import ttdhc_pkg::*;

   localparam int WATCH_LIMIT = 20000;
   localparam logic [1:0] MODE_SPARE = 2'd3;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_ready;
   req_type    req_payload = '0;
   logic       rsp_valid;
   logic       rsp_ready = 1'b0;
   rsp_type    rsp_payload;
   logic       csr_we = 1'b0;
   logic [2:0] csr_index = '0;
   logic [30:0] csr_wdata = '0;

   turn_then_drive_heading_controller_core dut (.*);

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // controller settings and arm state held by the model
   longint gain_q, arrive_q, align_q, cruise_q, maxturn_q;
   bit     armed;

   req_type pending_beats[$];
   rsp_type twist_expected[$];
   int      errors = 0;
   int      idle_cycles = 0;
   bit      req_taken = 0;
   int      gap_left = 0;
   int      stall_left = 0;

   function automatic longint shr_a(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint cordic_angle(longint y, longint x);
      longint z, xn, yn, t;
      longint tab[16] = '{51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
                          256, 128, 64, 32, 16, 8, 4, 2};
      z = 0;
      if (x == 0 && y == 0) return 0;
      x = x * 1048576;
      y = y * 1048576;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y; y = -t; z = 102944;
         end else begin
            x = -y; y = t; z = -102944;
         end
      end
      for (int i = 0; i < 16; i++) begin
         if (y >= 0) begin
            xn = x + shr_a(y, i); yn = y - shr_a(x, i); z += tab[i];
         end else begin
            xn = x - shr_a(y, i); yn = y + shr_a(x, i); z -= tab[i];
         end
         x = xn; y = yn;
      end
      return z;
   endfunction

   function automatic longint quat_heading(longint qz, longint qw);
      return cordic_angle(2 * qw * qz, qw * qw - qz * qz);
   endfunction

   function automatic longint steer_rate(longint tgt, longint cur);
      longint e;
      e = (tgt - cur) % 205887;
      return (e * gain_q) / 4096;
   endfunction

   function automatic longint absl(longint v);
      return v < 0 ? -v : v;
   endfunction

   task automatic predict_twist(req_type b);
      longint dx, dy, yaw, w, v;
      bit near_goal;
      rsp_type r;
      v = 0;
      r = '0;
      if (b.mode == MODE_GOAL) begin
         armed = 1;
         return;
      end
      if (b.mode == MODE_STOP) begin
         armed = 0;
         twist_expected.push_back(r);
         return;
      end
      if (b.mode != MODE_TICK || !armed) return;
      dx = longint'(b.target_x) - longint'(b.current_x);
      dy = longint'(b.target_y) - longint'(b.current_y);
      yaw = quat_heading(b.current_qz, b.current_qw);
      if (absl(dx) >= 64'sd2147483648 || absl(dy) >= 64'sd2147483648) near_goal = 0;
      else near_goal = (dx * dx + dy * dy) < arrive_q * arrive_q;
      if (near_goal) begin
         w = steer_rate(quat_heading(b.target_qz, b.target_qw), yaw);
         if (absl(w) < align_q) begin
            armed = 0;
            r.arrived = 1'b1;
            twist_expected.push_back(r);
            return;
         end
      end else begin
         w = steer_rate(cordic_angle(dy, dx), yaw);
         if (absl(w) < align_q) v = cruise_q;
      end
      if (w < -maxturn_q) w = -maxturn_q;
      else if (w > maxturn_q) w = maxturn_q;
      r.linear_velocity = v[14:0];
      r.angular_velocity = w[15:0];
      r.done_res = (v == 0 && w == 0);
      twist_expected.push_back(r);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      errors++;
      $display("mismatch %s: got %0d expected %0d at %0t", what, got, want, $time);
   endtask

   // driver
   always @(negedge clock) begin
      if (!reset) begin
         if (req_valid && req_taken) begin
            predict_twist(req_payload);
            if (pending_beats.size() > 0 && gap_left == 0) begin
               req_payload <= pending_beats.pop_front();
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                      : $urandom_range(0, 2);
            end else begin
               req_valid <= 1'b0;
            end
         end else if (!req_valid && pending_beats.size() > 0) begin
            if (gap_left > 0) gap_left--;
            else begin
               req_payload <= pending_beats.pop_front();
               req_valid <= 1'b1;
               gap_left = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 60)
                                                      : $urandom_range(0, 2);
            end
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
            if ($urandom_range(0, 5) == 0)
               stall_left = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 80)
                                                        : $urandom_range(1, 3);
         end
      end
   end

   // monitor and watchdog
   always @(posedge clock) begin
      rsp_type want;
      if (!reset) begin
         req_taken = req_valid && req_ready;
         idle_cycles++;
         if (req_taken) idle_cycles = 0;
         if (rsp_valid && rsp_ready) begin
            idle_cycles = 0;
            if (twist_expected.size() == 0) report_mismatch("unexpected beat", 1, 0);
            else begin
               want = twist_expected.pop_front();
               if (rsp_payload.linear_velocity !== want.linear_velocity)
                  report_mismatch("linear_velocity", rsp_payload.linear_velocity,
                                  want.linear_velocity);
               if (rsp_payload.angular_velocity !== want.angular_velocity)
                  report_mismatch("angular_velocity", rsp_payload.angular_velocity,
                                  want.angular_velocity);
               if (rsp_payload.done_res !== want.done_res)
                  report_mismatch("done_res", rsp_payload.done_res, want.done_res);
               if (rsp_payload.arrived !== want.arrived)
                  report_mismatch("arrived", rsp_payload.arrived, want.arrived);
            end
         end
         if (idle_cycles > WATCH_LIMIT) begin
            $display("TB_ERROR");
            $finish;
         end
      end
   end

   function automatic logic signed [15:0] rand_q();
      int k;
      k = $urandom_range(0, 9);
      if (k == 0) return 16'sd16384;
      if (k == 1) return -16'sd16384;
      if (k == 2) return 16'sd0;
      if (k == 3) return 16'($urandom);
      return 16'(int'($urandom_range(0, 32768)) - 16384);
   endfunction

   function automatic req_type rand_tick(bit nearby);
      req_type b;
      b.mode = MODE_TICK;
      b.current_x = $urandom;
      b.current_y = $urandom;
      if (nearby) begin
         b.target_x = b.current_x + int'($urandom_range(0, 16000)) - 8000;
         b.target_y = b.current_y + int'($urandom_range(0, 16000)) - 8000;
      end else if ($urandom_range(0, 1)) begin
         b.target_x = b.current_x + int'($urandom_range(0, 2000000)) - 1000000;
         b.target_y = b.current_y + int'($urandom_range(0, 2000000)) - 1000000;
      end else begin
         b.target_x = $urandom;
         b.target_y = $urandom;
      end
      b.current_qz = rand_q(); b.current_qw = rand_q();
      b.target_qz = rand_q(); b.target_qw = rand_q();
      if ($urandom_range(0, 7) == 0) begin
         b.target_qz = b.current_qz; b.target_qw = b.current_qw;
      end
      return b;
   endfunction

   task automatic make_beat(logic [1:0] m);
      req_type b;
      b = rand_tick(1'($urandom_range(0, 1)));
      b.mode = m;
      pending_beats.push_back(b);
   endtask

   task automatic write_csr(logic [2:0] idx, longint val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val[30:0];
      case (idx)
         CSR_RATE_GAIN: gain_q = val & 16'hFFFF;
         CSR_ARRIVE:    arrive_q = val & 31'h7FFFFFFF;
         CSR_ALIGN:     align_q = val & 15'h7FFF;
         CSR_CRUISE:    cruise_q = val & 15'h7FFF;
         default:       maxturn_q = val & 15'h7FFF;
      endcase
      @(negedge clock);
      csr_we <= 1'b0;
   endtask

   task automatic wait_drained();
      while (pending_beats.size() > 0 || req_valid || twist_expected.size() > 0)
         @(posedge clock);
      repeat (80) @(posedge clock);
   endtask

   initial begin
      req_type b;
      gain_q = 256; arrive_q = 6554; align_q = 4096; cruise_q = 819; maxturn_q = 8192;
      armed = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed beats
      make_beat(MODE_STOP);
      make_beat(MODE_TICK);
      make_beat(MODE_GOAL);
      b = '0; b.mode = MODE_TICK;
      pending_beats.push_back(b);
      make_beat(MODE_GOAL);
      b = '0; b.mode = MODE_TICK;
      b.current_x = 32'sh80000000; b.target_x = 32'sh7FFFFFFF;
      b.current_qz = 16'sd16384; b.target_qw = -16'sd16384;
      pending_beats.push_back(b);
      b.current_x = 32'sh7FFFFFFF; b.target_x = 32'sh80000000;
      b.current_y = 32'sh80000000; b.target_y = 32'sh7FFFFFFF;
      b.current_qz = -16'sd16384; b.current_qw = 16'sd0;
      pending_beats.push_back(b);
      b = '0; b.mode = MODE_TICK; b.target_x = -32'sd1000000;
      b.current_qw = -16'sd1; b.target_qz = 16'sd1;
      pending_beats.push_back(b);
      b = '0; b.mode = MODE_TICK; b.target_x = 32'sd100;
      b.current_qw = 16'sd16384; b.target_qz = 16'sd16384;
      pending_beats.push_back(b);
      b.target_qz = 16'sd0;
      pending_beats.push_back(b);
      b.mode = MODE_SPARE;
      pending_beats.push_back(b);
      make_beat(MODE_STOP);
      make_beat(MODE_STOP);
      wait_drained();

      for (int phase = 0; phase < 6; phase++) begin
         case (phase)
            0: begin
               write_csr(CSR_RATE_GAIN, 65535); write_csr(CSR_ARRIVE, 0);
               write_csr(CSR_ALIGN, 32767); write_csr(CSR_CRUISE, 32767);
               write_csr(CSR_MAX_TURN, 32767);
            end
            1: begin
               write_csr(CSR_RATE_GAIN, 0); write_csr(CSR_ARRIVE, 32'h7FFFFFFF);
               write_csr(CSR_ALIGN, 0); write_csr(CSR_CRUISE, 0);
               write_csr(CSR_MAX_TURN, 0);
            end
            2: begin
               write_csr(CSR_RATE_GAIN, 256); write_csr(CSR_ARRIVE, 6554);
               write_csr(CSR_ALIGN, 4096); write_csr(CSR_CRUISE, 819);
               write_csr(CSR_MAX_TURN, 8192);
            end
            default: begin
               write_csr(CSR_RATE_GAIN, $urandom_range(0, 65535));
               write_csr(CSR_ARRIVE, $urandom_range(0, 12000));
               write_csr(CSR_ALIGN, $urandom_range(0, 32767));
               write_csr(CSR_CRUISE, $urandom_range(0, 32767));
               write_csr(CSR_MAX_TURN, $urandom_range(0, 32767));
            end
         endcase
         for (int n = 0; n < 232; n++) begin
            case ($urandom_range(0, 19))
               0, 1: make_beat(MODE_GOAL);
               2:    make_beat(MODE_STOP);
               3:    make_beat(MODE_SPARE);
               default: begin
                  if ($urandom_range(0, 15) == 0) make_beat(MODE_GOAL);
                  pending_beats.push_back(rand_tick($urandom_range(0, 3) == 0));
               end
            endcase
         end
         if (phase == 3) begin
            // hold off until the pipe has emptied, then resume
            while (pending_beats.size() > 120) @(posedge clock);
            begin : hold_off
               req_type held[$];
               held = pending_beats;
               pending_beats.delete();
               while (req_valid || twist_expected.size() > 0) @(posedge clock);
               pending_beats = held;
            end
         end
         wait_drained();
      end
      if (errors == 0) $display("TB_OK");
      else $display("TB_ERROR");
      $finish;
   end

endmodule
